// File: rtl/core/iir_pkg.sv
package iir_pkg;

  localparam int MaxOrder    = 2;
  localparam int MaxChannels = 16;
  localparam int SlotCount   = MaxOrder + 1;
  localparam int HistDepth   = SlotCount * MaxChannels;
  localparam int ChanW       = 4;
  localparam int SlotW       = 2;
  localparam int AddrW       = SlotW + ChanW;
  localparam int SampleW     = 32;
  localparam int CoefW       = 24;
  localparam int ProdW       = SampleW + CoefW;
  localparam int AccW        = 64;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 24;
  localparam int OrderW      = 2;
  localparam int NchW        = 5;
  localparam int DivCntW     = 5;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegOrder    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegChannels = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNum0     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegNum1     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNum2     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDen0     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDen1     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDen2     = 3'd7;

  localparam logic signed [CoefW-1:0] CoefOne = 24'sd1048576;
  localparam logic [SampleW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [SampleW-1:0] SatNeg = 32'h8000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULX,
    S_RD,
    S_MULB,
    S_MULA,
    S_ACC,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                 done;
    logic                 sat;
    logic [SampleW-1:0]   quotient;
  } div_res_t;

endpackage

// File: rtl/core/iir_if.sv
interface iir_in_if (input logic clk);
  logic                            valid;
  logic                            ready;
  logic signed [iir_pkg::SampleW-1:0] sample;
  logic [iir_pkg::ChanW-1:0]       channel;

  modport source (output valid, output sample, output channel, input ready);
  modport sink (input valid, input sample, input channel, output ready);
endinterface

interface iir_out_if (input logic clk);
  logic                               valid;
  logic                               ready;
  logic signed [iir_pkg::SampleW-1:0] filtered_sample;
  logic [iir_pkg::ChanW-1:0]          out_channel;
  logic                               saturated;
  logic                               warming_up;

  modport source (output valid, output filtered_sample, output out_channel,
                  output saturated, output warming_up, input ready);
  modport sink (input valid, input filtered_sample, input out_channel,
                input saturated, input warming_up, output ready);
endinterface

// File: rtl/core/iir_ram.sv
module iir_ram #(
  parameter int Width = 32,
  parameter int Depth = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/iir_div.sv
module iir_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [iir_pkg::AccW-1:0]    dividend,
  input  logic signed [iir_pkg::CoefW-1:0]   divisor,
  output iir_pkg::div_res_t                  res
);

  logic                         busy;
  logic                         done;
  logic [iir_pkg::DivCntW-1:0]  cnt;
  logic [iir_pkg::CoefW-1:0]    rem;
  logic [iir_pkg::AccW-1:0]     quo;
  logic [iir_pkg::CoefW-1:0]    dmag;
  logic                         neg;
  logic                         zero;
  logic                         acc_neg;

  logic [iir_pkg::CoefW-1:0]    rem_next;
  logic [iir_pkg::AccW-1:0]     quo_next;
  logic [iir_pkg::CoefW:0]      trial;
  logic                         over;

  // two restoring steps per cycle
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_next, quo_next[iir_pkg::AccW-1]};
      if (trial >= {1'b0, dmag}) begin
        trial = trial - {1'b0, dmag};
        quo_next = {quo_next[iir_pkg::AccW-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[iir_pkg::AccW-2:0], 1'b0};
      end
      rem_next = trial[iir_pkg::CoefW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= (divisor != '0);
        done <= (divisor == '0);
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quo     <= dividend[iir_pkg::AccW-1] ? (~dividend + 1'b1) : dividend;
      dmag    <= divisor[iir_pkg::CoefW-1] ? (~divisor + 1'b1) : divisor;
      neg     <= dividend[iir_pkg::AccW-1] ^ divisor[iir_pkg::CoefW-1];
      zero    <= (divisor == '0);
      acc_neg <= dividend[iir_pkg::AccW-1];
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  always_comb begin
    over = neg ? ((quo[iir_pkg::AccW-1:32] != '0) || (quo[31] && (quo[30:0] != '0)))
               : (quo[iir_pkg::AccW-1:31] != '0);
    res.done = done;
    if (zero) begin
      res.sat      = 1'b1;
      res.quotient = acc_neg ? iir_pkg::SatNeg : iir_pkg::SatPos;
    end else if (over) begin
      res.sat      = 1'b1;
      res.quotient = neg ? iir_pkg::SatNeg : iir_pkg::SatPos;
    end else begin
      res.sat      = 1'b0;
      res.quotient = neg ? (~quo[iir_pkg::SampleW-1:0] + 1'b1) : quo[iir_pkg::SampleW-1:0];
    end
  end

  property p_done_not_busy;
    @(posedge clk) disable iff (rst) done |-> !busy;
  endproperty
  a_done_not_busy: assert property (p_done_not_busy) else $error("divider done while busy");

  property p_start_idle;
    @(posedge clk) disable iff (rst) start |-> !busy;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("divider restarted while busy");

  property p_zero_done;
    @(posedge clk) disable iff (rst) (start && divisor == '0) |=> done;
  endproperty
  a_zero_done: assert property (p_zero_done) else $error("zero divisor not finished at once");

endmodule

// File: rtl/core/multichannel_iir_filter.sv
// channel   dir  payload                                               transfer
// samples   in   sample[31:0] Q16.16, channel[3:0]                     valid & ready
// results   out  filtered_sample[31:0], out_channel, saturated, warm   valid & ready
// cfg       in   cfg_write, cfg_index[2:0], cfg_data[23:0]             cfg_write
//
// warm-up sample: accepted, then shown the next cycle
// filtered sample: the shared 32x24 MAC sums b0*x, then b*x and -a*y per tap; the serial
//   divider by a0 (2 bits a cycle over a 64-bit sum) then forms the result
// one sample at a time: ready is high only while idle
// a stalled result holds until taken; nothing else moves meanwhile
// synchronous reset clears the sequencer, position and warm-up flag and resets the config registers;
//   history memories are not cleared
module multichannel_iir_filter (
  input  logic                           clk,
  input  logic                           rst,
  iir_in_if.sink                         samples,
  iir_out_if.source                      results,
  input  logic                           cfg_write,
  input  logic [iir_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [iir_pkg::CfgDataW-1:0]   cfg_data
);

  iir_pkg::state_t state, state_next;

  // configuration registers
  logic [iir_pkg::OrderW-1:0]       order;
  logic [iir_pkg::NchW-1:0]         channels_in_use;
  logic signed [iir_pkg::CoefW-1:0] num_coef [iir_pkg::SlotCount];
  logic signed [iir_pkg::CoefW-1:0] den_coef [iir_pkg::SlotCount];

  // shared state across channels
  logic [iir_pkg::SlotW-1:0] position;
  logic                      filter_ready;

  // per-item registers
  logic signed [iir_pkg::SampleW-1:0] x;
  logic [iir_pkg::ChanW-1:0]          ch;
  logic [iir_pkg::SlotW-1:0]          k;
  logic [iir_pkg::OrderW-1:0]         ord;
  logic [iir_pkg::OrderW-1:0]         j;
  logic signed [iir_pkg::ProdW-1:0]   prod;
  logic                               prod_vld;
  logic                               prod_sub;
  logic signed [iir_pkg::AccW-1:0]    acc;
  logic [iir_pkg::SampleW-1:0]        y;
  logic                               sat;
  logic                               warm;
  logic                               div_started;

  // sequencer outputs
  logic accept;
  logic mul_en;
  logic mul_sub;
  logic div_start;

  // effective settings
  logic [iir_pkg::OrderW-1:0] ord_eff;
  logic [iir_pkg::NchW-1:0]   nch_eff;
  logic [iir_pkg::SlotW-1:0]  k_eff;
  logic [iir_pkg::SlotW:0]    k_inc;

  // history memories
  logic [iir_pkg::AddrW-1:0]   rd_addr;
  logic [iir_pkg::SlotW:0]     slot_sum;
  logic [iir_pkg::SlotW-1:0]   rd_slot;
  logic [iir_pkg::SampleW-1:0] xh_data;
  logic [iir_pkg::SampleW-1:0] yh_data;
  logic                        yh_we;
  logic [iir_pkg::AddrW-1:0]   yh_waddr;
  logic [iir_pkg::SampleW-1:0] yh_wdata;

  // shared multiplier operands
  logic signed [iir_pkg::SampleW-1:0] mul_x;
  logic signed [iir_pkg::CoefW-1:0]   mul_c;

  iir_pkg::div_res_t div_res;

  assign accept  = samples.valid && samples.ready;
  assign ord_eff = (order > iir_pkg::OrderW'(iir_pkg::MaxOrder))
                   ? iir_pkg::OrderW'(iir_pkg::MaxOrder) : order;
  assign nch_eff = (channels_in_use == '0) ? iir_pkg::NchW'(1)
                 : (channels_in_use > iir_pkg::NchW'(iir_pkg::MaxChannels))
                   ? iir_pkg::NchW'(iir_pkg::MaxChannels) : channels_in_use;
  // stale position after order was lowered
  assign k_eff   = (position > ord_eff) ? '0 : position;
  assign k_inc   = {1'b0, k_eff} + 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      order           <= '0;
      channels_in_use <= iir_pkg::NchW'(1);
      num_coef[0]     <= iir_pkg::CoefOne;
      num_coef[1]     <= '0;
      num_coef[2]     <= '0;
      den_coef[0]     <= iir_pkg::CoefOne;
      den_coef[1]     <= '0;
      den_coef[2]     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        iir_pkg::RegOrder:    order           <= cfg_data[iir_pkg::OrderW-1:0];
        iir_pkg::RegChannels: channels_in_use <= cfg_data[iir_pkg::NchW-1:0];
        iir_pkg::RegNum0:     num_coef[0]     <= cfg_data;
        iir_pkg::RegNum1:     num_coef[1]     <= cfg_data;
        iir_pkg::RegNum2:     num_coef[2]     <= cfg_data;
        iir_pkg::RegDen0:     den_coef[0]     <= cfg_data;
        iir_pkg::RegDen1:     den_coef[1]     <= cfg_data;
        iir_pkg::RegDen2:     den_coef[2]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // history position advances after the last channel of a vector
  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      filter_ready <= 1'b0;
    end else if (accept) begin
      if ({1'b0, samples.channel} == nch_eff - 1'b1) begin
        if (k_inc > {1'b0, ord_eff}) begin
          position     <= '0;
          filter_ready <= 1'b1;
        end else begin
          position <= k_inc[iir_pkg::SlotW-1:0];
        end
      end else begin
        position <= k_eff;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iir_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      iir_pkg::S_IDLE: begin
        if (accept) begin
          state_next = filter_ready ? iir_pkg::S_MULX : iir_pkg::S_OUT;
        end
      end
      iir_pkg::S_MULX: state_next = (ord == '0) ? iir_pkg::S_ACC : iir_pkg::S_RD;
      iir_pkg::S_RD:   state_next = iir_pkg::S_MULB;
      iir_pkg::S_MULB: state_next = iir_pkg::S_MULA;
      iir_pkg::S_MULA: state_next = (j == ord) ? iir_pkg::S_ACC : iir_pkg::S_RD;
      iir_pkg::S_ACC:  state_next = iir_pkg::S_DIV;
      iir_pkg::S_DIV:  state_next = div_res.done ? iir_pkg::S_OUT : iir_pkg::S_DIV;
      iir_pkg::S_OUT:  state_next = results.ready ? iir_pkg::S_IDLE : iir_pkg::S_OUT;
      default:         state_next = iir_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    samples.ready = 1'b0;
    results.valid = 1'b0;
    mul_en        = 1'b0;
    mul_sub       = 1'b0;
    div_start     = 1'b0;
    mul_x         = x;
    mul_c         = num_coef[0];
    case (state)
      iir_pkg::S_IDLE: samples.ready = 1'b1;
      iir_pkg::S_MULX: mul_en = 1'b1;
      iir_pkg::S_MULB: begin
        mul_en = 1'b1;
        mul_x  = xh_data;
        mul_c  = num_coef[j];
      end
      iir_pkg::S_MULA: begin
        mul_en  = 1'b1;
        mul_sub = 1'b1;
        mul_x   = yh_data;
        mul_c   = den_coef[j];
      end
      // last product lands in the sum during S_ACC, divider starts on entry to S_DIV
      iir_pkg::S_DIV:  div_start = !div_started;
      iir_pkg::S_OUT:  results.valid = 1'b1;
      default: ;
    endcase
  end

  // tap index, per-item latches
  always_ff @(posedge clk) begin
    if (accept) begin
      x           <= samples.sample;
      ch          <= samples.channel;
      k           <= k_eff;
      ord         <= ord_eff;
      j           <= iir_pkg::OrderW'(1);
      warm        <= !filter_ready;
      y           <= samples.sample;
      sat         <= 1'b0;
      div_started <= 1'b0;
    end else begin
      if (state == iir_pkg::S_MULA && j != ord) begin
        j <= j + 1'b1;
      end
      if (div_start) begin
        div_started <= 1'b1;
      end
      if (div_res.done) begin
        y   <= div_res.quotient;
        sat <= div_res.sat;
      end
    end
  end

  // one shared multiplier, registered, then accumulated
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod     <= mul_x * mul_c;
      prod_sub <= mul_sub;
    end
    if (accept) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= prod_sub ? acc - iir_pkg::AccW'(prod) : acc + iir_pkg::AccW'(prod);
    end
  end

  // slot of tap j: (k - j) mod (ord + 1)
  assign slot_sum = (k >= j) ? ({1'b0, k} - {1'b0, j})
                             : ({1'b0, k} + {1'b0, ord} + 1'b1 - {1'b0, j});
  assign rd_slot  = slot_sum[iir_pkg::SlotW-1:0];
  assign rd_addr  = {rd_slot, ch};

  // output history written at accept during warm-up, else when the quotient is ready
  assign yh_we    = (accept && !filter_ready) || div_res.done;
  assign yh_waddr = accept ? {k_eff, samples.channel} : {k, ch};
  assign yh_wdata = accept ? samples.sample : div_res.quotient;

  iir_ram #(
    .Width (iir_pkg::SampleW),
    .Depth (iir_pkg::HistDepth)
  ) u_xhist (
    .clk   (clk),
    .we    (accept),
    .waddr ({k_eff, samples.channel}),
    .wdata (samples.sample),
    .raddr (rd_addr),
    .rdata (xh_data)
  );

  iir_ram #(
    .Width (iir_pkg::SampleW),
    .Depth (iir_pkg::HistDepth)
  ) u_yhist (
    .clk   (clk),
    .we    (yh_we),
    .waddr (yh_waddr),
    .wdata (yh_wdata),
    .raddr (rd_addr),
    .rdata (yh_data)
  );

  iir_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (den_coef[0]),
    .res      (div_res)
  );

  assign results.filtered_sample = y;
  assign results.out_channel     = ch;
  assign results.saturated       = sat;
  assign results.warming_up      = warm;

  property p_one_at_a_time;
    @(posedge clk) disable iff (rst) accept |=> !samples.ready;
  endproperty
  a_one_at_a_time: assert property (p_one_at_a_time) else $error("second sample taken early");

  property p_not_both;
    @(posedge clk) disable iff (rst) results.valid |-> !samples.ready;
  endproperty
  a_not_both: assert property (p_not_both) else $error("ready while result pending");

  property p_warm_no_sat;
    @(posedge clk) disable iff (rst) (results.valid && results.warming_up) |-> !results.saturated;
  endproperty
  a_warm_no_sat: assert property (p_warm_no_sat) else $error("warm-up result saturated");

  property p_div_done_state;
    @(posedge clk) disable iff (rst) div_res.done |-> (state == iir_pkg::S_DIV);
  endproperty
  a_div_done_state: assert property (p_div_done_state) else $error("quotient outside divide");

  property p_pos_range;
    @(posedge clk) disable iff (rst) position <= iir_pkg::SlotW'(iir_pkg::MaxOrder);
  endproperty
  a_pos_range: assert property (p_pos_range) else $error("history position out of range");

endmodule
